/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/gto_pkg.sv */
// ----------------------------------------------------------------------------
// gto_pkg
// Types and constants shared by the glyph text overlay modules.
// ----------------------------------------------------------------------------
package gto_pkg;

    localparam int ADDR_W      = 10;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 11;
    localparam int LUMA_W      = 8;
    localparam int DY_W        = 4;
    localparam int GLYPH_DOTS  = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int TDATA_W     = 48;

    localparam logic [LUMA_W-1:0] INK_LUMA = 8'hFF;

    localparam int FRAME_W_DEF    = 1920;
    localparam int FRAME_H_DEF    = 1080;
    localparam int CHAR_COUNT_DEF = 32;
    localparam int CELL_PITCH_DEF = 18;

    typedef enum logic [0:0] {
        CFG_START_X = 1'b0,
        CFG_START_Y = 1'b1
    } gto_cfg_idx_t;

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_PIXEL = 1'b1
    } gto_req_t;

    typedef struct packed {
        logic cap;
        logic step;
    } gto_adv_t;

    typedef struct packed {
        logic              is_load;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] gbyte;
        logic [LUMA_W-1:0] luma;
        logic              inkable;
        logic [2:0]        bit_sel;
    } gto_loc_t;

endpackage

/* src/glyph_text_overlay.sv */
// ----------------------------------------------------------------------------
// glyph_text_overlay
// Draws a row of 16x16 bitmap glyphs from a 1024-byte store onto a luma
// pixel stream.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless its output stalls, glyph
// loads and pixels mixed in any order, and returns one result per pixel;
// loads give no result. Stage one finds the offset from the text origin and
// a reciprocal estimate of the cell number, stage two corrects it and
// addresses the single-port glyph store, whose registered read feeds the
// output stage. Loads write the store in the same stage where pixels read
// it, so a pixel always sees every load accepted before it, and the store
// needs no clearing pass after reset. Stalled results hold in the output
// register while empty stages upstream keep filling.
module glyph_text_overlay #(
    parameter int FRAME_W    = gto_pkg::FRAME_W_DEF,
    parameter int FRAME_H    = gto_pkg::FRAME_H_DEF,
    parameter int CHAR_COUNT = gto_pkg::CHAR_COUNT_DEF,
    parameter int CELL_PITCH = gto_pkg::CELL_PITCH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // glyph_addr, glyph_byte, pixel_x, pixel_y, luma_in
    input  logic [gto_pkg::TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // luma_out
    output logic [gto_pkg::LUMA_W-1:0]    m_tdata,
    // ink_hit
    output logic                          m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  gto_pkg::gto_cfg_idx_t         cfg_index,
    input  logic [gto_pkg::COORD_W-1:0]   cfg_data
);
    import gto_pkg::*;

    logic [COORD_W-1:0] start_x_reg;
    logic [COORD_W-1:0] start_y_reg;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic free1, free2, free3;
    logic s_fire;

    gto_adv_t adv;
    gto_loc_t loc;

    logic              mem_wr;
    logic              mem_rd;
    logic [BYTE_W-1:0] rd_data;

    logic [LUMA_W-1:0] luma3_reg;
    logic              inkable3_reg;
    logic [2:0]        bit_sel3_reg;
    logic              ink;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_X: start_x_reg <= cfg_data;
                CFG_START_Y: start_y_reg <= cfg_data;
                default:     start_x_reg <= start_x_reg;
            endcase
        end
    end

    assign free3    = !v3_reg || m_tready;
    assign free2    = !v2_reg || loc.is_load || free3;
    assign free1    = !v1_reg || free2;
    assign s_tready = free1;
    assign s_fire   = s_tvalid && free1;

    assign adv.cap  = s_fire;
    assign adv.step = free2;

    assign mem_wr = v2_reg && loc.is_load;
    assign mem_rd = v2_reg && !loc.is_load && free3;

    always_comb
    begin
        v1_next = s_fire ? 1'b1 : (free2 ? 1'b0 : v1_reg);
        v2_next = free2 ? v1_reg : v2_reg;
        v3_next = free3 ? (v2_reg && !loc.is_load) : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    gto_locate #(
        .FRAME_W    (FRAME_W),
        .FRAME_H    (FRAME_H),
        .CHAR_COUNT (CHAR_COUNT),
        .CELL_PITCH (CELL_PITCH)
    ) u_locate (
        .clk        (clk),
        .adv        (adv),
        .req_type   (s_tuser),
        .glyph_addr (s_tdata[9:0]),
        .glyph_byte (s_tdata[17:10]),
        .pixel_x    (s_tdata[28:18]),
        .pixel_y    (s_tdata[39:29]),
        .luma_in    (s_tdata[47:40]),
        .start_x    (start_x_reg),
        .start_y    (start_y_reg),
        .loc        (loc)
    );

    gto_glyph_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (loc.addr),
        .wdata   (loc.gbyte),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            luma3_reg    <= loc.luma;
            inkable3_reg <= loc.inkable;
            bit_sel3_reg <= loc.bit_sel;
        end
    end

    assign ink      = inkable3_reg && rd_data[3'd7 - bit_sel3_reg];
    assign m_tvalid = v3_reg;
    assign m_tdata  = ink ? INK_LUMA : luma3_reg;
    assign m_tuser  = ink;

endmodule

/* src/gto_glyph_mem.sv */
// ----------------------------------------------------------------------------
// gto_glyph_mem
// Glyph byte store: one shared port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module gto_glyph_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic                        rd_en,
    input  logic [gto_pkg::ADDR_W-1:0]  addr,
    input  logic [gto_pkg::BYTE_W-1:0]  wdata,
    output logic [gto_pkg::BYTE_W-1:0]  rd_data
);
    import gto_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/gto_locate.sv */
// ----------------------------------------------------------------------------
// gto_locate
// Two pipeline stages that map a pixel coordinate to a glyph byte address,
// a bit select and an ink window flag.
// ----------------------------------------------------------------------------
module gto_locate #(
    parameter int FRAME_W    = gto_pkg::FRAME_W_DEF,
    parameter int FRAME_H    = gto_pkg::FRAME_H_DEF,
    parameter int CHAR_COUNT = gto_pkg::CHAR_COUNT_DEF,
    parameter int CELL_PITCH = gto_pkg::CELL_PITCH_DEF
) (
    input  logic                         clk,
    input  gto_pkg::gto_adv_t            adv,
    input  logic                         req_type,
    input  logic [gto_pkg::ADDR_W-1:0]   glyph_addr,
    input  logic [gto_pkg::BYTE_W-1:0]   glyph_byte,
    input  logic [gto_pkg::COORD_W-1:0]  pixel_x,
    input  logic [gto_pkg::COORD_W-1:0]  pixel_y,
    input  logic [gto_pkg::LUMA_W-1:0]   luma_in,
    input  logic [gto_pkg::COORD_W-1:0]  start_x,
    input  logic [gto_pkg::COORD_W-1:0]  start_y,
    output gto_pkg::gto_loc_t            loc
);
    import gto_pkg::*;

    localparam int QW     = $clog2((2 ** COORD_W) / CELL_PITCH + 1);
    localparam int RW     = $clog2(2 * CELL_PITCH);
    localparam int PROD_W = COORD_W + RECIP_SHIFT;
    localparam int EDGE_W = 13;

    localparam logic [PROD_W-1:0]  Recip   = PROD_W'((2 ** RECIP_SHIFT) / CELL_PITCH);
    localparam logic [COORD_W-1:0] PitchW  = COORD_W'(CELL_PITCH);
    localparam logic [RW-1:0]      PitchR  = RW'(CELL_PITCH);
    localparam logic [RW-1:0]      DotsR   = RW'(GLYPH_DOTS);
    localparam logic [QW:0]        CharLim = (QW + 1)'(CHAR_COUNT);
    localparam logic [EDGE_W-1:0]  EdgeX   = EDGE_W'(FRAME_W - 1);
    localparam logic [EDGE_W-1:0]  EdgeY   = EDGE_W'(FRAME_H - 1);

    logic [COORD_W-1:0] dx_in;
    logic [COORD_W-1:0] dy_in;
    logic               pre_ok_in;

    logic               is_load1_reg;
    logic [ADDR_W-1:0]  gaddr1_reg;
    logic [BYTE_W-1:0]  gbyte1_reg;
    logic [LUMA_W-1:0]  luma1_reg;
    logic [COORD_W-1:0] dx1_reg;
    logic [DY_W-1:0]    dy1_reg;
    logic               pre_ok1_reg;

    logic [PROD_W-1:0]  prod;
    logic [QW-1:0]      q_next;

    logic               is_load2_reg;
    logic [ADDR_W-1:0]  gaddr2_reg;
    logic [BYTE_W-1:0]  gbyte2_reg;
    logic [LUMA_W-1:0]  luma2_reg;
    logic [COORD_W-1:0] dx2_reg;
    logic [DY_W-1:0]    dy2_reg;
    logic               pre_ok2_reg;
    logic [QW-1:0]      q2_reg;

    logic [COORD_W-1:0] qp;
    logic [COORD_W-1:0] rem_full;
    logic [RW-1:0]      rem;
    logic [QW-1:0]      char_idx;
    logic [RW-1:0]      col;
    logic               char_ok;
    logic               col_ok;

    assign dx_in     = pixel_x - start_x;
    assign dy_in     = pixel_y - start_y;
    assign pre_ok_in = (pixel_x >= start_x) && (pixel_y >= start_y)
                    && (dy_in < COORD_W'(GLYPH_DOTS))
                    && ({2'b00, pixel_x} < EdgeX) && ({2'b00, pixel_y} < EdgeY);

    always_ff @(posedge clk)
    begin
        if (adv.cap)
        begin
            is_load1_reg <= (req_type == REQ_LOAD);
            gaddr1_reg   <= glyph_addr;
            gbyte1_reg   <= glyph_byte;
            luma1_reg    <= luma_in;
            dx1_reg      <= dx_in;
            dy1_reg      <= dy_in[DY_W-1:0];
            pre_ok1_reg  <= pre_ok_in;
        end
    end

    // The reciprocal estimate is exact or one below the true quotient.
    assign prod   = PROD_W'(dx1_reg) * Recip;
    assign q_next = prod[RECIP_SHIFT +: QW];

    always_ff @(posedge clk)
    begin
        if (adv.step)
        begin
            is_load2_reg <= is_load1_reg;
            gaddr2_reg   <= gaddr1_reg;
            gbyte2_reg   <= gbyte1_reg;
            luma2_reg    <= luma1_reg;
            dx2_reg      <= dx1_reg;
            dy2_reg      <= dy1_reg;
            pre_ok2_reg  <= pre_ok1_reg;
            q2_reg       <= q_next;
        end
    end

    assign qp       = COORD_W'(q2_reg) * PitchW;
    assign rem_full = dx2_reg - qp;
    assign rem      = rem_full[RW-1:0];

    always_comb
    begin
        if (rem >= PitchR)
        begin
            char_idx = q2_reg + QW'(1);
            col      = rem - PitchR;
        end
        else
        begin
            char_idx = q2_reg;
            col      = rem;
        end
    end

    assign char_ok = {1'b0, char_idx} < CharLim;
    assign col_ok  = col < DotsR;

    always_comb
    begin
        loc.is_load = is_load2_reg;
        loc.addr    = is_load2_reg ? gaddr2_reg : {char_idx[4:0], dy2_reg, col[3]};
        loc.gbyte   = gbyte2_reg;
        loc.luma    = luma2_reg;
        loc.inkable = pre_ok2_reg && char_ok && col_ok;
        loc.bit_sel = col[2:0];
    end

endmodule

/* src/gto_checker.sv */
// ----------------------------------------------------------------------------
// gto_props
// Port-level checks of the glyph text overlay, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gto_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [gto_pkg::TDATA_W-1:0]   s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gto_pkg::LUMA_W-1:0]    m_tdata,
    input logic                          m_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input gto_pkg::gto_cfg_idx_t         cfg_index,
    input logic [gto_pkg::COORD_W-1:0]   cfg_data
);
    import gto_pkg::*;

    `ASSERT_CLK_RST(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ASSERT_CLK_RST(a_ink_luma, clk, rst_n, m_tvalid && m_tuser |-> m_tdata == INK_LUMA, "inked result is not full luma")
    `ASSERT_CLK_RST(a_ready_idle, clk, rst_n, !m_tvalid |-> s_tready, "input stalled with no result waiting")
    `ASSERT_CLK(a_cfg_ready, clk, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind glyph_text_overlay gto_props u_gto_props (.*);

/* test/gto_checker.sv */
// ----------------------------------------------------------------------------
// gto_checker
// Watches the pixel, result and register channels of the glyph text overlay,
// keeps its own glyph store and text origin, and compares every result with
// the luma and ink flag expected for the oldest pixel still waiting.
// ----------------------------------------------------------------------------
module gto_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // glyph_addr, glyph_byte, pixel_x, pixel_y, luma_in
    input  logic [gto_pkg::TDATA_W-1:0]   s_tdata,
    // req_type
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // luma_out
    input  logic [gto_pkg::LUMA_W-1:0]    m_tdata,
    // ink_hit
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  gto_pkg::gto_cfg_idx_t         cfg_index,
    input  logic [gto_pkg::COORD_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            outstanding
);
    import gto_pkg::*;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic              ink;
    } overlay_t;

    logic [BYTE_W-1:0]  glyph_mem [STORE_DEPTH];
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    overlay_t           luma_expected [$];

    function automatic overlay_t overlay_pixel(logic [COORD_W-1:0] px,
                                               logic [COORD_W-1:0] py,
                                               logic [LUMA_W-1:0] luma);
        int                dx;
        int                dy;
        int                char_idx;
        int                col;
        logic [ADDR_W-1:0] addr;
        overlay_t          res;
        res.luma = luma;
        res.ink  = 1'b0;
        if (px < FRAME_W_DEF - 1 && py < FRAME_H_DEF - 1 && px >= org_x && py >= org_y)
        begin
            dx       = px - org_x;
            dy       = py - org_y;
            char_idx = dx / CELL_PITCH_DEF;
            col      = dx % CELL_PITCH_DEF;
            if (dy < GLYPH_DOTS && char_idx < CHAR_COUNT_DEF && col < GLYPH_DOTS)
            begin
                addr = ADDR_W'(char_idx * 32 + dy * 2 + col / 8);
                if (glyph_mem[addr][7 - col % 8])
                begin
                    res.luma = INK_LUMA;
                    res.ink  = 1'b1;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        overlay_t want;
        if (!rst_n)
        begin
            org_x = '0;
            org_y = '0;
            luma_expected.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START_X)
                    org_x = cfg_data;
                else
                    org_y = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (luma_expected.size() == 0)
                begin
                    $error("result item with no pixel waiting: luma_out %0d ink_hit %0d",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = luma_expected.pop_front();
                    if (m_tdata !== want.luma)
                    begin
                        $error("luma_out mismatch: expected %0d, actual %0d",
                               want.luma, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.ink)
                    begin
                        $error("ink_hit mismatch: expected %0d, actual %0d",
                               want.ink, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == REQ_LOAD)
                    glyph_mem[s_tdata[9:0]] = s_tdata[17:10];
                else
                    luma_expected.push_back(overlay_pixel(s_tdata[28:18], s_tdata[39:29],
                                                          s_tdata[47:40]));
            end
            outstanding = luma_expected.size();
        end
    end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the glyph text overlay: loads glyph bytes and streams pixels
// around the text line under several text origins and flow-control patterns,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import gto_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b1;
    logic [LUMA_W-1:0]  m_tdata;
    logic               m_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    gto_cfg_idx_t       cfg_index;
    logic [COORD_W-1:0] cfg_data;
    int                 fail_count;
    int                 outstanding;
    int                 cycles = 0;

    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    bit                 written [STORE_DEPTH];
    bit                 tx_idle;
    bit                 rx_idle;
    int                 idle_pct;

    glyph_text_overlay u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gto_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready = rx_idle ? ($urandom_range(99) >= idle_pct) : 1'b1;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Store address that a pixel reads, or -1 where it reads none.
    function automatic int glyph_index(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        int dx;
        int dy;
        if (px >= FRAME_W_DEF - 1 || py >= FRAME_H_DEF - 1 || px < org_x || py < org_y)
            return -1;
        dx = px - org_x;
        dy = py - org_y;
        if (dy >= GLYPH_DOTS || dx / CELL_PITCH_DEF >= CHAR_COUNT_DEF
            || dx % CELL_PITCH_DEF >= GLYPH_DOTS)
            return -1;
        return (dx / CELL_PITCH_DEF) * 32 + dy * 2 + (dx % CELL_PITCH_DEF) / 8;
    endfunction

    task automatic drive_item(gto_req_t req, logic [TDATA_W-1:0] data);
        while (tx_idle && $urandom_range(99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic load_byte(int addr, logic [BYTE_W-1:0] value);
        logic [29:0] junk;
        junk = 30'($urandom);
        written[addr] = 1'b1;
        drive_item(REQ_LOAD, {junk, value, ADDR_W'(addr)});
    endtask

    // Loads a missing glyph byte first, so no pixel reads an unwritten entry.
    task automatic pass_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [LUMA_W-1:0] luma);
        int idx;
        idx = glyph_index(px, py);
        if (idx >= 0 && !written[idx])
            load_byte(idx, BYTE_W'($urandom));
        drive_item(REQ_PIXEL, {luma, py, px, BYTE_W'($urandom), ADDR_W'($urandom)});
    endtask

    task automatic write_reg(gto_cfg_idx_t idx, logic [COORD_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == CFG_START_X)
            org_x = value;
        else
            org_y = value;
    endtask

    task automatic drain;
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    initial
    begin
        int          ph;
        int          n;
        int          r;
        logic [10:0] nx;
        logic [10:0] ny;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_X;
        cfg_data  = '0;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        idle_pct  = 56;
        org_x     = '0;
        org_y     = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(CFG_START_X, 11'd0);
        write_reg(CFG_START_Y, 11'd0);
        load_byte(0, 8'h80);
        load_byte(1, 8'h01);
        load_byte(STORE_DEPTH - 1, 8'hFF);
        pass_pixel(11'd0, 11'd0, 8'd0);
        pass_pixel(11'd1, 11'd0, 8'd255);
        pass_pixel(11'd15, 11'd0, 8'h7F);
        pass_pixel(11'd16, 11'd0, 8'h80);
        pass_pixel(11'd17, 11'd0, 8'd1);
        pass_pixel(11'd573, 11'd15, 8'd0);
        pass_pixel(11'd576, 11'd0, 8'd0);
        pass_pixel(11'd0, 11'd16, 8'd0);
        pass_pixel(11'd2047, 11'd2047, 8'd0);
        drain();
        write_reg(CFG_START_X, 11'd1903);
        write_reg(CFG_START_Y, 11'd1064);
        load_byte(28, 8'hFF);
        pass_pixel(11'd1918, 11'd1064, 8'd3);
        pass_pixel(11'd1919, 11'd1064, 8'd3);
        pass_pixel(11'd1903, 11'd1078, 8'd3);
        pass_pixel(11'd1903, 11'd1079, 8'd3);
        pass_pixel(11'd1902, 11'd1064, 8'd3);
        pass_pixel(11'd1903, 11'd1063, 8'd3);

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:       begin nx = 11'd0;    ny = 11'd0;    end
                1:       begin nx = 11'd1919; ny = 11'd1079; end
                2:       begin nx = 11'd1903; ny = 11'd1064; end
                3:       begin nx = 11'd1340; ny = 11'd1070; end
                4:       begin nx = 11'd1000; ny = 11'd500;  end
                default: begin nx = 11'($urandom_range(1919)); ny = 11'($urandom_range(1079)); end
            endcase
            write_reg(CFG_START_X, nx);
            write_reg(CFG_START_Y, ny);
            tx_idle  = (ph % 4 == 1) || (ph % 4 == 3);
            rx_idle  = (ph % 4 == 2) || (ph % 4 == 3);
            idle_pct = (tx_idle && rx_idle) ? 35 : 56;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    load_byte($urandom_range(STORE_DEPTH - 1), BYTE_W'($urandom));
                else if (r < 30)
                    pass_pixel(11'($urandom), 11'($urandom), 8'($urandom));
                else
                    pass_pixel(11'(org_x + $urandom_range(CHAR_COUNT_DEF * CELL_PITCH_DEF + 3) - 2),
                               11'(org_y + $urandom_range(18) - 1), 8'($urandom));
            end
        end

        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/gto_pkg.sv
src/gto_glyph_mem.sv
src/gto_locate.sv
src/glyph_text_overlay.sv
src/gto_checker.sv
test/gto_checker.sv
test/tb.sv
